[hw/rtl/afsk_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the AFSK transmitter.
package afsk_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int SINE_ADDR_BITS = 10;
    localparam int QTR_BITS       = SINE_ADDR_BITS - 2;
    localparam int QTR_SIZE       = 1 << QTR_BITS;
    localparam int MAG_BITS       = 15;
    localparam int SAMPLE_BITS    = 16;
    localparam int SPB_BITS       = 16;
    localparam int INC_BITS       = 31;
    localparam int AMP_BITS       = 15;
    localparam int BYTE_BITS      = 8;
    localparam int CNT_BITS       = 4;
    localparam int CFG_DATA_BITS  = 31;
    localparam int CFG_IDX_BITS   = 3;

    localparam logic [BYTE_BITS-1:0]     PREAMBLE  = 8'hAA;
    localparam logic [MAG_BITS-1:0]      MAG_PEAK  = 15'd32767;
    localparam logic [CNT_BITS-1:0]      BITS_FULL = 4'd8;
    localparam logic [SPB_BITS-1:0]      SPB_RST   = 16'd441;
    localparam logic [INC_BITS-1:0]      SPACE_RST = 31'd116869866;
    localparam logic [INC_BITS-1:0]      MARK_RST  = 31'd214261410;
    localparam logic [AMP_BITS-1:0]      AMP_RST   = 15'd26214;
    localparam logic [BYTE_BITS-1:0]     KEY_RST   = 8'd75;
    localparam logic [63:0]              PI_Q62    = 64'hC90FDAA22168C235;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BIT_TICKS       = 3'd0,
        CFG_PHASE_INC_SPACE = 3'd1,
        CFG_PHASE_INC_MARK  = 3'd2,
        CFG_AMPLITUDE       = 3'd3,
        CFG_XOR_KEY         = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                 start_message;
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] data_byte;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          byte_taken;
        logic                          idle;
    } out_t;

    typedef struct packed {
        logic [SPB_BITS-1:0]  bit_ticks;
        logic [INC_BITS-1:0]  phase_inc_space;
        logic [INC_BITS-1:0]  phase_inc_mark;
        logic [AMP_BITS-1:0]  amplitude;
        logic [BYTE_BITS-1:0] xor_key;
    } cfg_t;

    typedef struct packed {
        logic                      active;
        logic                      taken;
        logic [SINE_ADDR_BITS-1:0] addr;
    } tone_t;

    typedef logic [QTR_SIZE-1:0][MAG_BITS-1:0] qtr_rom_t;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[125:62];
    endfunction

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [MAG_BITS-1:0] quarter_sine(input int j);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] t;
        logic [63:0] r;
        logic [63:0] d;
        x  = qmul(PI_Q62, 64'(j) << (63 - SINE_ADDR_BITS));
        x2 = qmul(x, x);
        s  = x;
        t  = x;
        for (int n = 1; n < 64 && t != 0; n++)
        begin
            d = 64'(2 * n) * 64'(2 * n + 1);
            t = udiv64(qmul(t, x2), d);
            if ((n & 1) != 0)
            begin
                s = s - t;
            end
            else
            begin
                s = s + t;
            end
        end
        r = (s >> 20) * 64'd32767;
        r = (r + (64'd1 << 41)) >> 42;
        return r[MAG_BITS-1:0];
    endfunction

    function automatic qtr_rom_t build_qtr_rom();
        qtr_rom_t rom;
        for (int k = 0; k < QTR_SIZE; k++)
        begin
            rom[k] = quarter_sine(k);
        end
        return rom;
    endfunction

    localparam qtr_rom_t QTR_ROM = build_qtr_rom();

endpackage

[hw/rtl/afsk_cfg_regs.sv]
// Configuration register bank for the AFSK transmitter.
module afsk_cfg_regs
    import afsk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_ticks       <= SPB_RST;
            cfg_reg.phase_inc_space <= SPACE_RST;
            cfg_reg.phase_inc_mark  <= MARK_RST;
            cfg_reg.amplitude       <= AMP_RST;
            cfg_reg.xor_key         <= KEY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_TICKS:       cfg_reg.bit_ticks       <= cfg_data[SPB_BITS-1:0];
                CFG_PHASE_INC_SPACE: cfg_reg.phase_inc_space <= cfg_data[INC_BITS-1:0];
                CFG_PHASE_INC_MARK:  cfg_reg.phase_inc_mark  <= cfg_data[INC_BITS-1:0];
                CFG_AMPLITUDE:       cfg_reg.amplitude       <= cfg_data[AMP_BITS-1:0];
                CFG_XOR_KEY:         cfg_reg.xor_key         <= cfg_data[BYTE_BITS-1:0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/afsk_bit_ctrl.sv]
// Byte loading, bit timing and phase accumulation; registers one tone beat per tick.
module afsk_bit_ctrl
    import afsk_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  in_t   in_data,
    input  cfg_t  cfg,
    input  logic  s2_ready,
    output logic  s1_valid,
    output tone_t s1
);

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [BYTE_BITS-1:0]  shift_reg;
    logic [BYTE_BITS-1:0]  shift_next;
    logic [CNT_BITS-1:0]   bits_reg;
    logic [CNT_BITS-1:0]   bits_next;
    logic [SPB_BITS-1:0]   sib_reg;
    logic [SPB_BITS-1:0]   sib_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    tone_t                 s1_reg;
    tone_t                 s1_next;

    logic                  accept;
    logic                  load_start;
    logic                  load_byte;
    logic [PHASE_BITS-1:0] cur_phase;
    logic [BYTE_BITS-1:0]  cur_shift;
    logic [CNT_BITS-1:0]   cur_bits;
    logic [SPB_BITS-1:0]   cur_sib;
    logic [SPB_BITS-1:0]   sib_inc;
    logic [INC_BITS-1:0]   inc;
    logic                  bit_end;

    assign in_ready = !s1_valid_reg || s2_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        load_start = (bits_reg == '0) && in_data.start_message;
        load_byte  = (bits_reg == '0) && !in_data.start_message && in_data.byte_valid;

        cur_phase = load_start ? '0 : phase_reg;
        cur_shift = load_start ? PREAMBLE
                  : load_byte  ? (in_data.data_byte ^ cfg.xor_key)
                  : shift_reg;
        cur_bits  = (load_start || load_byte) ? BITS_FULL : bits_reg;
        cur_sib   = (load_start || load_byte) ? '0 : sib_reg;

        inc     = cur_shift[BYTE_BITS-1] ? cfg.phase_inc_mark : cfg.phase_inc_space;
        sib_inc = cur_sib + 1'b1;
        bit_end = (sib_inc >= cfg.bit_ticks) || (sib_inc == '0);

        s1_next.active = (cur_bits != '0);
        s1_next.taken  = load_byte;
        s1_next.addr   = cur_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];

        phase_next = cur_phase;
        shift_next = cur_shift;
        bits_next  = cur_bits;
        sib_next   = cur_sib;
        if (cur_bits != '0)
        begin
            phase_next = cur_phase + PHASE_BITS'(inc);
            sib_next   = sib_inc;
            if (bit_end)
            begin
                sib_next   = '0;
                shift_next = {cur_shift[BYTE_BITS-2:0], 1'b0};
                bits_next  = cur_bits - 1'b1;
            end
        end

        s1_valid_next = in_ready ? accept : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            shift_reg    <= '0;
            bits_reg     <= '0;
            sib_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                bits_reg  <= bits_next;
                sib_reg   <= sib_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= BITS_FULL)
        else $error("bit count above one byte");

    a_idle_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg == '0 |-> sib_reg == '0)
        else $error("sample counter not cleared while idle");

    a_taken_active: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.taken |-> s1_reg.active)
        else $error("byte taken on an idle tick");

endmodule

[hw/rtl/afsk_sine_scale.sv]
// Sine lookup from the quarter-wave table, amplitude scaling and the result register.
module afsk_sine_scale
    import afsk_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s1_valid,
    input  tone_t               s1,
    input  logic [AMP_BITS-1:0] amplitude,
    output logic                s2_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output out_t                out_data
);

    logic                      out_valid_reg;
    out_t                      out_reg;
    out_t                      out_next;

    logic [1:0]                quad;
    logic [QTR_BITS-1:0]       qidx;
    logic [QTR_BITS-1:0]       tidx;
    logic                      peak;
    logic [MAG_BITS-1:0]       mag;
    logic [MAG_BITS+AMP_BITS-1:0] prod;
    logic [SAMPLE_BITS-1:0]    scaled;

    assign s2_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        quad   = s1.addr[SINE_ADDR_BITS-1 -: 2];
        qidx   = s1.addr[QTR_BITS-1:0];
        tidx   = quad[0] ? (QTR_BITS'(0) - qidx) : qidx;
        peak   = quad[0] && (qidx == '0);
        mag    = peak ? MAG_PEAK : QTR_ROM[tidx];
        prod   = MAG_BITS'(mag) * AMP_BITS'(amplitude);
        scaled = {1'b0, prod[MAG_BITS+AMP_BITS-1 -: MAG_BITS]};

        out_next.byte_taken = s1.taken;
        out_next.idle       = !s1.active;
        if (!s1.active)
        begin
            out_next.sample = '0;
        end
        else if (quad[1])
        begin
            out_next.sample = SAMPLE_BITS'(16'd0 - scaled);
        end
        else
        begin
            out_next.sample = scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.idle |-> out_reg.sample == '0)
        else $error("nonzero sample on an idle tick");

    a_taken_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_taken |-> !out_reg.idle)
        else $error("byte taken but tick reported idle");

endmodule

[hw/rtl/afsk_byte_transmitter.sv]
// Top level of the AFSK byte transmitter: config bank, bit control and sine scaling.
// An accepted beat is registered first in the tone register of the bit control and then
// in the result register of the sine scaling, from which it is offered as the result beat.
// Throughput: one beat per cycle; the input stalls only when both the input register
// and the result register hold beats and the result beat is not taken.
// Reset: asynchronous, active low; clears bit state and phase, loads register defaults.
module afsk_byte_transmitter
    import afsk_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  in_t                      in_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output out_t                     out_data,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t  cfg;
    logic  s2_ready;
    logic  s1_valid;
    tone_t s1;

    afsk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afsk_bit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg),
        .s2_ready (s2_ready),
        .s1_valid (s1_valid),
        .s1       (s1)
    );

    afsk_sine_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1        (s1),
        .amplitude (cfg.amplitude),
        .s2_ready  (s2_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[test/tb.sv]
// Testbench for the AFSK byte transmitter: predicts each sample tick and checks every result beat.
`timescale 1ns / 100ps

module tb;
    import afsk_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_NO_REG = 3'd5;
    localparam int ROM_SIZE = 1 << SINE_ADDR_BITS;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    in_t                      in_data = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    out_t                     out_data;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    afsk_byte_transmitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // modulator state and register bank of the prediction
    cfg_t                  regs;
    logic [PHASE_BITS-1:0] tone_phase;
    logic [BYTE_BITS-1:0]  tx_shift;
    logic [CNT_BITS-1:0]   bits_left;
    logic [SPB_BITS-1:0]   tick_in_bit;
    int                    sine_table [0:ROM_SIZE-1];

    in_t  tick_q [$];
    out_t pending_samples [$];
    int   ticks_queued = 0;
    int   ticks_taken = 0;
    int   mismatches = 0;
    bit   in_fire = 1'b0;
    bit   idling_on = 1'b1;
    int   send_gap = 0;
    int   take_gap = 0;

    function automatic out_t modulate_tick(input in_t tick);
        out_t                  res;
        int                    level;
        int                    mag;
        int                    scaled;
        logic [PHASE_BITS-1:0] tone_step;
        res = '0;
        if (bits_left == 0)
        begin
            if (tick.start_message)
            begin
                tx_shift    = PREAMBLE;
                bits_left   = BITS_FULL;
                tick_in_bit = '0;
                tone_phase  = '0;
            end
            else if (tick.byte_valid)
            begin
                tx_shift       = tick.data_byte ^ regs.xor_key;
                bits_left      = BITS_FULL;
                tick_in_bit    = '0;
                res.byte_taken = 1'b1;
            end
        end
        if (bits_left != 0)
        begin
            level  = sine_table[tone_phase[PHASE_BITS-1 -: SINE_ADDR_BITS]];
            mag    = (level < 0) ? -level : level;
            scaled = (mag * int'(regs.amplitude)) >>> 15;
            res.sample = SAMPLE_BITS'((level < 0) ? -scaled : scaled);
            tone_step  = tx_shift[BYTE_BITS-1] ? PHASE_BITS'(regs.phase_inc_mark)
                                               : PHASE_BITS'(regs.phase_inc_space);
            tone_phase  = tone_phase + tone_step;
            tick_in_bit = tick_in_bit + 1'b1;
            if (tick_in_bit >= regs.bit_ticks || tick_in_bit == 0)
            begin
                tick_in_bit = '0;
                tx_shift    = tx_shift << 1;
                bits_left   = bits_left - 1'b1;
            end
            res.idle = 1'b0;
        end
        else
        begin
            res.idle = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [30:0] pick_level(input logic [30:0] top);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return top;
            default: return 31'($urandom % ({1'b0, top} + 32'd1));
        endcase
    endfunction

    task automatic queue_tick(input logic start, input logic valid, input logic [7:0] data);
        in_t tick;
        tick.start_message = start;
        tick.byte_valid    = valid;
        tick.data_byte     = data;
        tick_q = {tick_q, tick};
        ticks_queued++;
    endtask

    task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [30:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BIT_TICKS:       regs.bit_ticks       = val[SPB_BITS-1:0];
            CFG_PHASE_INC_SPACE: regs.phase_inc_space = val[INC_BITS-1:0];
            CFG_PHASE_INC_MARK:  regs.phase_inc_mark  = val[INC_BITS-1:0];
            CFG_AMPLITUDE:       regs.amplitude       = val[AMP_BITS-1:0];
            CFG_XOR_KEY:         regs.xor_key         = val[BYTE_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (ticks_taken != ticks_queued || pending_samples.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("status: fail");
        $finish;
    end

    // sender: hold the beat until taken, then idle in bursts or advance
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else if (tick_q.size() > 0)
            begin
                in_data  <= tick_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (take_gap > 0)
        begin
            take_gap--;
            out_ready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            take_gap = $urandom_range(0, 6);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                pending_samples = {pending_samples, modulate_tick(in_data)};
                ticks_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_samples.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with none expected, sample %0d",
                             $time, $signed(out_data.sample));
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (out_data.sample !== want.sample)
                    begin
                        mismatches++;
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 $signed(want.sample), $signed(out_data.sample));
                    end
                    if (out_data.byte_taken !== want.byte_taken)
                    begin
                        mismatches++;
                        $display("%0t: byte_taken expected %0b actual %0b", $time,
                                 want.byte_taken, out_data.byte_taken);
                    end
                    if (out_data.idle !== want.idle)
                    begin
                        mismatches++;
                        $display("%0t: idle expected %0b actual %0b", $time,
                                 want.idle, out_data.idle);
                    end
                end
            end
        end
    end

    initial
    begin
        int                  q;
        int                  j;
        int                  mag;
        int                  r;
        logic [SPB_BITS-1:0] spb;
        logic [30:0]         lvl;
        for (int k = 0; k < ROM_SIZE; k++)
        begin
            q   = k >> QTR_BITS;
            j   = k & (QTR_SIZE - 1);
            j   = (q & 1) ? QTR_SIZE - j : j;
            mag = $rtoi(32767.0 * $sin(3.14159265358979323846 * j / (2.0 * QTR_SIZE)) + 0.5);
            sine_table[k] = (q & 2) ? -mag : mag;
        end
        regs.bit_ticks       = SPB_RST;
        regs.phase_inc_space = SPACE_RST;
        regs.phase_inc_mark  = MARK_RST;
        regs.amplitude       = AMP_RST;
        regs.xor_key         = KEY_RST;
        tone_phase  = '0;
        tx_shift    = '0;
        bits_left   = '0;
        tick_in_bit = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // idle ticks, start beating a byte, requests while busy
        queue_tick(1'b0, 1'b0, 8'h00);
        queue_tick(1'b0, 1'b0, 8'hFF);
        queue_tick(1'b1, 1'b1, 8'h5A);
        queue_tick(1'b1, 1'b0, 8'h00);
        queue_tick(1'b0, 1'b1, 8'hFF);
        queue_tick(1'b1, 1'b1, 8'h81);
        wait_quiet();

        // shorten the bit under way, then finish the preamble
        set_reg(CFG_BIT_TICKS, 31'd2);
        for (int i = 0; i < 15; i++)
        begin
            queue_tick(1'b0, 1'b1, 8'h3C);
        end
        wait_quiet();

        set_reg(CFG_BIT_TICKS, 31'd0);
        set_reg(CFG_PHASE_INC_SPACE, 31'd0);
        set_reg(CFG_PHASE_INC_MARK, 31'h7FFFFFFF);
        set_reg(CFG_AMPLITUDE, 31'd32767);
        set_reg(CFG_XOR_KEY, 31'd255);
        set_reg(CFG_NO_REG, 31'h5A5A5A5A);
        queue_tick(1'b0, 1'b1, 8'h00);
        queue_tick(1'b0, 1'b1, 8'hFF);
        queue_tick(1'b1, 1'b1, 8'h00);
        wait_quiet();

        // longest bit, cut short by a lower count
        set_reg(CFG_BIT_TICKS, 31'd65535);
        set_reg(CFG_AMPLITUDE, 31'($urandom_range(1, 32767)));
        queue_tick(1'b1, 1'b0, 8'h00);
        for (int i = 0; i < 40; i++)
        begin
            queue_tick(1'($urandom), 1'($urandom), 8'($urandom));
        end
        wait_quiet();
        set_reg(CFG_BIT_TICKS, 31'd1);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 7)
            begin
                idling_on = 1'b0;
            end
            spb = ($urandom_range(0, 3) == 0) ? SPB_BITS'($urandom_range(0, 1))
                                              : SPB_BITS'($urandom_range(1, 9));
            set_reg(CFG_BIT_TICKS, {15'($urandom), spb});
            set_reg(CFG_PHASE_INC_SPACE, pick_level(31'h7FFFFFFF));
            set_reg(CFG_PHASE_INC_MARK, pick_level(31'h7FFFFFFF));
            lvl = pick_level(31'd32767);
            set_reg(CFG_AMPLITUDE, {16'($urandom), lvl[AMP_BITS-1:0]});
            lvl = pick_level(31'd255);
            set_reg(CFG_XOR_KEY, {23'($urandom), lvl[BYTE_BITS-1:0]});
            for (int i = 0; i < 85; i++)
            begin
                r = $urandom_range(0, 15);
                queue_tick(r == 0, r >= 4, 8'($urandom));
            end
            wait_quiet();
        end

        repeat (10) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/afsk_pkg.sv
hw/rtl/afsk_cfg_regs.sv
hw/rtl/afsk_bit_ctrl.sv
hw/rtl/afsk_sine_scale.sv
hw/rtl/afsk_byte_transmitter.sv
test/tb.sv
